// ===== sv/dq_pkg.sv =====
// Shared constants, codes and ring address arithmetic for the double-ended queue.
// Used by the top level, the slot memory wrapper users and the port checker.
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_ERASE      = 3'd4,
    OP_SEARCH     = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_PEEK       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Ring position of an offset from a base slot; the offset never exceeds DEPTH.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== sv/dq_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// Holds the slot words of the queue; depends on nothing else.
module dq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/double_ended_queue_top.sv =====
// Double-ended queue top level: request sequencer, ring pointers and result register.
// Depends on dq_pkg and the dq_ram slot memory.
// Push, pop, clear and peek go from accept through the front and back reads to the result,
// skipping the back read when the queue is left empty; search and erase first walk the held
// words through the single memory read port, one per cycle. One request is in flight at a time;
// the next is accepted from the cycle its result appears; its result waits behind a stalled one.
// Reset clears the pointers, the count and the sequencer; slot words are not cleared.
module double_ended_queue_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          op,
  input  logic signed [dq_pkg::WORD_WIDTH-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic                                found,
  output logic signed [dq_pkg::WORD_WIDTH-1:0] front_value,
  output logic signed [dq_pkg::WORD_WIDTH-1:0] back_value,
  output logic [dq_pkg::CNT_W-1:0]            entry_count
);

  import dq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_READ_F,
    S_READ_B,
    S_DONE
  } state_t;

  state_t               state;
  op_t                  op_r;
  logic [WORD_WIDTH-1:0] word;
  logic [IDX_W-1:0]     front_index;
  logic [CNT_W-1:0]     occupancy;
  logic [CNT_W-1:0]     cnt;
  status_t              status_r;
  logic                 found_r;
  logic [WORD_WIDTH-1:0] front_word;

  logic                  accept;
  op_t                   op_in;
  logic                  full;
  logic                  is_empty;
  logic                  match;
  logic [IDX_W-1:0]      front_dec;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [WORD_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [WORD_WIDTH-1:0] rd_data;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign op_in     = op_t'(op);
  assign full      = (occupancy >= CNT_W'(DEPTH));
  assign is_empty  = (occupancy == '0);
  assign match     = (rd_data == word);
  assign front_dec = (front_index == '0) ? IDX_W'(DEPTH - 1) : front_index - IDX_W'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = front_index;
    wr_data = value;
    rd_en   = 1'b0;
    rd_addr = front_index;
    unique case (state)
      S_IDLE: begin
        if (accept && !full && (op_in == OP_PUSH_FRONT)) begin
          wr_en   = 1'b1;
          wr_addr = front_dec;
        end else if (accept && !full && (op_in == OP_PUSH_BACK)) begin
          wr_en   = 1'b1;
          wr_addr = ring_add(front_index, occupancy);
        end
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = ring_add(front_index, cnt);
      end
      S_SHIFT: begin
        if (cnt < occupancy) begin
          wr_en   = 1'b1;
          wr_addr = ring_add(front_index, cnt - CNT_W'(1));
          wr_data = rd_data;
          rd_en   = 1'b1;
          rd_addr = ring_add(front_index, cnt + CNT_W'(1));
        end
      end
      S_READ_F: begin
        rd_en   = !is_empty;
        rd_addr = front_index;
      end
      S_READ_B: begin
        rd_en   = 1'b1;
        rd_addr = ring_add(front_index, occupancy - CNT_W'(1));
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  dq_ram #(
    .DEPTH(DEPTH),
    .WIDTH(WORD_WIDTH),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front_index <= '0;
      occupancy   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_r     <= op_in;
            word     <= value;
            status_r <= ST_OK;
            found_r  <= 1'b0;
            cnt      <= '0;
            state    <= S_READ_F;
            unique case (op_in)
              OP_PUSH_FRONT: begin
                if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  front_index <= front_dec;
                  occupancy   <= occupancy + CNT_W'(1);
                end
              end
              OP_PUSH_BACK: begin
                if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  occupancy <= occupancy + CNT_W'(1);
                end
              end
              OP_POP_FRONT: begin
                if (is_empty) begin
                  status_r <= ST_EMPTY;
                end else begin
                  front_index <= ring_add(front_index, CNT_W'(1));
                  occupancy   <= occupancy - CNT_W'(1);
                end
              end
              OP_POP_BACK: begin
                if (is_empty) begin
                  status_r <= ST_EMPTY;
                end else begin
                  occupancy <= occupancy - CNT_W'(1);
                end
              end
              OP_ERASE: begin
                if (is_empty) begin
                  status_r <= ST_EMPTY;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_SEARCH: begin
                if (is_empty) begin
                  status_r <= ST_MISSING;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_CLEAR: begin
                if (is_empty) begin
                  status_r <= ST_EMPTY;
                end else begin
                  occupancy   <= '0;
                  front_index <= '0;
                end
              end
              OP_PEEK: begin
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          // The word read in the previous cycle sits at offset cnt - 1.
          if ((cnt != '0) && match) begin
            found_r <= 1'b1;
            state   <= (op_r == OP_ERASE) ? S_SHIFT : S_READ_F;
          end else if (cnt == occupancy) begin
            status_r <= ST_MISSING;
            state    <= S_READ_F;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_SHIFT: begin
          if (cnt < occupancy) begin
            cnt <= cnt + CNT_W'(1);
          end else begin
            occupancy <= occupancy - CNT_W'(1);
            state     <= S_READ_F;
          end
        end
        S_READ_F: begin
          state <= is_empty ? S_DONE : S_READ_B;
        end
        S_READ_B: begin
          front_word <= rd_data;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= status_r;
            found       <= found_r;
            front_value <= is_empty ? '0 : front_word;
            back_value  <= is_empty ? '0 : rd_data;
            entry_count <= occupancy;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/dq_checker.sv =====
// Port-level checker for the double-ended queue and its bind to the top level.
// Depends on dq_pkg for the depth and status codes.
module dq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [2:0]                          op,
  input logic signed [dq_pkg::WORD_WIDTH-1:0] value,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [1:0]                          status,
  input logic                                found,
  input logic signed [dq_pkg::WORD_WIDTH-1:0] front_value,
  input logic signed [dq_pkg::WORD_WIDTH-1:0] back_value,
  input logic [dq_pkg::CNT_W-1:0]            entry_count
);

  import dq_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !in_stall && !out_valid)
    else $error("Block not idle after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(found) &&
      $stable(front_value) && $stable(back_value) && $stable(entry_count))
    else $error("Stalled result changed.");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= CNT_W'(DEPTH)) &&
      ((entry_count != '0) || ((front_value == '0) && (back_value == '0))))
    else $error("Bad count or nonzero ends on an empty queue.");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> (status == ST_OK))
    else $error("Found flag with a failing status.");

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (.*);
